/* sv/mpq_pkg.sv */
// shared constants and types for the mpq string hash block
package mpq_pkg;

   localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
   localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
   localparam logic [31:0] SEED_TWO_ADD  = 32'd3;

   localparam int          LCG_WIDTH = 22;
   localparam logic [21:0] LCG_INIT  = 22'h100001;
   localparam logic [21:0] LCG_MOD   = 22'h2AAAAB;
   localparam logic [6:0]  LCG_MUL   = 7'd125;
   localparam logic [2:0]  LCG_STEPS = 3'd7;
   localparam logic [1:0]  LCG_ADD   = 2'd3;

   localparam logic [2:0]  TABLE_LAST_ROW = 3'd4;
   localparam logic [7:0]  TABLE_LAST_COL = 8'hFF;

   localparam int          WINDOW_DEPTH = 256;
   localparam int          QUEUE_DEPTH  = 4;

   typedef struct packed {
      logic [31:0]       entry;
      logic signed [7:0] character;
      logic              last_char;
   } item_type;

endpackage

/* sv/mpq_if.sv */
// valid/ready channel interfaces for characters and hash results
interface mpq_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] character;
   logic              last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface mpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_one;
   logic [31:0] hash_two;

   modport source (output valid, output hash_one, output hash_two, input ready);
   modport sink   (input valid, input hash_one, input hash_two, output ready);
endinterface

/* sv/mpq_string_hash.sv */
// top level of the mpq string hash block
//
// req carries one signed filename character per item, last_char marks the
// end of a string. rsp carries hash_one and hash_two, one item per string,
// given when the item with last_char set is hashed.
// After reset an internal generator builds the 256 needed crypt table
// entries; each generator draw takes one multiplier bit per step, two
// draws make one generated entry and 256 of the 1280 entries are kept,
// while req.ready stays low. Seeds start at their initial values.
// Throughput is one character per cycle while req.ready is high, set by
// the single table ram read port and one seed update per pop. A last
// character passes the ram read register, the queue and the result
// register before it shows up on rsp.
// When rsp stalls, non-last characters keep flowing; a last character waits
// in the queue until the result register frees, and once the queue fills
// req.ready drops.
module mpq_string_hash #(
   parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mpq_req_if.sink    req,
   mpq_rsp_if.source  rsp
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic              push;
   mpq_pkg::item_type push_item;
   logic              pop;
   mpq_pkg::item_type head_item;
   logic              not_empty;
   logic [CW-1:0]     queue_count;

   mpq_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   mpq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (not_empty),
      .count     (queue_count)
   );

   mpq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

/* sv/mpq_ram.sv */
// generic single write port ram with registered read
module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mpq_queue.sv */
// short fifo between the lookup front and the hash back
module mpq_queue #(
   parameter int DEPTH = mpq_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mpq_pkg::item_type          push_item,
   input  logic                       pop,
   output mpq_pkg::item_type          head_item,
   output logic                       not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   mpq_pkg::item_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

/* sv/mpq_front.sv */
// table generator, character intake and crypt table lookup
module mpq_front #(
   parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   mpq_req_if.sink                          req,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                             push,
   output mpq_pkg::item_type                push_item
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int WW = $clog2(mpq_pkg::WINDOW_DEPTH);

   typedef enum logic {
      GEN_RUN,
      GEN_DONE
   } gen_state_type;

   gen_state_type state_ff, state_in;
   logic [21:0] lcg_ff, lcg_in;
   logic [21:0] acc_ff, acc_in;
   logic [2:0]  step_ff, step_in;
   logic        half_ff, half_in;
   logic [2:0]  row_ff, row_in;
   logic [7:0]  col_ff, col_in;
   logic [15:0] hi_ff, hi_in;

   logic [23:0] acc_sum;
   logic [23:0] acc_red;
   logic        mul_bit;
   logic        last_step;
   logic        tbl_wr;
   logic [WW-1:0] tbl_addr;

   logic        accept;
   logic        rd_valid_ff;
   logic signed [7:0] char_ff;
   logic        last_ff;
   logic [31:0] entry;

   // one bit of the multiplier per cycle, kept below the modulus
   always_comb begin
      last_step = (step_ff == mpq_pkg::LCG_STEPS - 3'd1);
      mul_bit   = mpq_pkg::LCG_MUL[3'd6 - step_ff];
      acc_sum   = {1'b0, acc_ff, 1'b0}
                + (mul_bit ? {2'b00, lcg_ff} : 24'd0)
                + (last_step ? {22'd0, mpq_pkg::LCG_ADD} : 24'd0);
      if (acc_sum >= {1'b0, mpq_pkg::LCG_MOD, 1'b0}) begin
         acc_red = acc_sum - {1'b0, mpq_pkg::LCG_MOD, 1'b0};
      end else if (acc_sum >= {2'b00, mpq_pkg::LCG_MOD}) begin
         acc_red = acc_sum - {2'b00, mpq_pkg::LCG_MOD};
      end else begin
         acc_red = acc_sum;
      end
   end

   always_comb begin
      state_in = state_ff;
      lcg_in   = lcg_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      half_in  = half_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      hi_in    = hi_ff;
      tbl_wr   = 1'b0;
      tbl_addr = {~col_ff[7], col_ff[6:0]};
      case (state_ff)
         GEN_RUN: begin
            if (!last_step) begin
               acc_in  = acc_red[21:0];
               step_in = step_ff + 3'd1;
            end else begin
               acc_in  = '0;
               step_in = '0;
               lcg_in  = acc_red[21:0];
               half_in = ~half_ff;
               if (!half_ff) begin
                  hi_in = acc_red[15:0];
               end else begin
                  // keep only table rows 128 to 383
                  tbl_wr = (row_ff == {2'b00, ~col_ff[7]});
                  if (row_ff == mpq_pkg::TABLE_LAST_ROW) begin
                     row_in = '0;
                     col_in = col_ff + 8'd1;
                     if (col_ff == mpq_pkg::TABLE_LAST_COL) begin
                        state_in = GEN_DONE;
                     end
                  end else begin
                     row_in = row_ff + 3'd1;
                  end
               end
            end
         end
         GEN_DONE: begin
            state_in = GEN_DONE;
         end
         default: begin
            state_in = GEN_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_RUN;
         lcg_ff   <= mpq_pkg::LCG_INIT;
         acc_ff   <= '0;
         step_ff  <= '0;
         half_ff  <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lcg_ff   <= lcg_in;
         acc_ff   <= acc_in;
         step_ff  <= step_in;
         half_ff  <= half_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
   end

   // room for queued items plus the one in the ram read
   assign req.ready = (state_ff == GEN_DONE)
                   && (({1'b0, queue_count} + (CW + 1)'(rd_valid_ff)) < (CW + 1)'(QUEUE_DEPTH));
   assign accept = req.valid && req.ready;

   mpq_ram #(
      .WIDTH (32),
      .DEPTH (mpq_pkg::WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (tbl_addr),
      .wr_data ({hi_ff, acc_red[15:0]}),
      .rd_en   (accept),
      .rd_addr ({~req.character[7], req.character[6:0]}),
      .rd_data (entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req.character;
         last_ff <= req.last_char;
      end
   end

   assign push                = rd_valid_ff;
   assign push_item.entry     = entry;
   assign push_item.character = char_ff;
   assign push_item.last_char = last_ff;

endmodule

/* sv/mpq_back.sv */
// seed update and result register
module mpq_back (
   input  logic              clock,
   input  logic              reset,
   input  mpq_pkg::item_type head_item,
   input  logic              not_empty,
   output logic              pop,
   mpq_rsp_if.source         rsp
);

   logic [31:0] seed_one_ff, seed_one_in;
   logic [31:0] seed_two_ff, seed_two_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_one_ff, hash_two_ff;
   logic [31:0] next_one;
   logic [31:0] next_two;
   logic        out_free;

   always_comb begin
      next_one = head_item.entry ^ (seed_one_ff + seed_two_ff);
      next_two = {{24{head_item.character[7]}}, head_item.character}
               + next_one + seed_two_ff + {seed_two_ff[26:0], 5'd0}
               + mpq_pkg::SEED_TWO_ADD;
      out_free = !rsp_valid_ff || rsp.ready;
      pop      = not_empty && (!head_item.last_char || out_free);

      seed_one_in  = seed_one_ff;
      seed_two_in  = seed_two_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (pop) begin
         if (head_item.last_char) begin
            seed_one_in  = mpq_pkg::SEED_ONE_INIT;
            seed_two_in  = mpq_pkg::SEED_TWO_INIT;
            rsp_valid_in = 1'b1;
         end else begin
            seed_one_in = next_one;
            seed_two_in = next_two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_one_ff  <= mpq_pkg::SEED_ONE_INIT;
         seed_two_ff  <= mpq_pkg::SEED_TWO_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_one_ff  <= seed_one_in;
         seed_two_ff  <= seed_two_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.last_char) begin
         hash_one_ff <= next_one;
         hash_two_ff <= next_two;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.hash_one = hash_one_ff;
   assign rsp.hash_two = hash_two_ff;

endmodule
